[rtl/i2cm_pkg.sv]
// Package for the I2C bus master core: command codes, sequencer phases,
// counter sizing and the SDA drive helper. No dependencies.
`default_nettype none

package i2cm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int LEN_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    localparam logic [CFG_WIDTH-1:0] HALF_PERIOD_RESET = CFG_WIDTH'(250);

    localparam logic [3:0] BIT_LAST_DATA = 4'd7;
    localparam logic [3:0] BIT_ACK       = 4'd8;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RS_SETUP  = 4'd1,
        PH_RS_WAIT   = 4'd2,
        PH_RS_HOLD   = 4'd3,
        PH_ST_HOLD   = 4'd4,
        PH_SP_SETUP  = 4'd5,
        PH_SP_WAIT   = 4'd6,
        PH_SP_HOLD   = 4'd7,
        PH_SP_TAIL   = 4'd8,
        PH_BIT_SETUP = 4'd9,
        PH_BIT_WAIT  = 4'd10,
        PH_BIT_HIGH  = 4'd11
    } phase_t;

    // SDA pull-down for the current bit: data bits on a write, the
    // acknowledge bit on a read, released otherwise.
    function automatic logic bit_drive(input logic is_write, input logic [3:0] bit_count,
                                       input logic msb, input logic nack);
        logic data_bit;
        data_bit = (bit_count < BIT_ACK);
        if (is_write)
        begin
            return data_bit ? ~msb : 1'b0;
        end
        return data_bit ? 1'b0 : ~nack;
    endfunction

endpackage

`default_nettype wire

[rtl/i2cm_if.sv]
// Handshake interfaces for the I2C bus master core: the tick channel in
// and the result channel out. Uses no package.
`default_nettype none

interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] write_data;
    logic       send_nack;
    logic       scl_in;
    logic       sda_in;

    modport source (output valid, cmd, write_data, send_nack, scl_in, sda_in, input ready);
    modport sink (input valid, cmd, write_data, send_nack, scl_in, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
    logic       bus_started;

    modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                    read_data, nack_seen, bus_started, input ready);
    modport sink (input valid, scl_pull_low, sda_pull_low, busy_res, done_res,
                  read_data, nack_seen, bus_started, output ready);
endinterface

`default_nettype wire

[rtl/i2c_bus_master_core.sv]
// Top level of the I2C bus master core: input register, bus sequencer and
// result register. Depends on i2cm_pkg and the interfaces in i2cm_if.sv.
//
// Each transaction on req is one bus tick carrying a command and the sampled
// SCL and SDA levels; each produces exactly one transaction on rsp with the
// pin drives and status after that tick. The core takes one transaction per
// clock cycle while rsp.ready does not stall it: a tick is held in the input
// register, the sequencer state advances, and the outcome sits in the result
// register. Every half SCL period lasts half_period_reg ticks (zero counts as
// one), and the core waits without limit for SCL to read high.
`default_nettype none

module i2c_bus_master_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [i2cm_pkg::CFG_WIDTH-1:0] cfg_wdata,
    i2cm_req_if.sink                            req,
    i2cm_rsp_if.source                          rsp
);

    localparam int CW = i2cm_pkg::COUNT_WIDTH;
    localparam int LW = i2cm_pkg::LEN_WIDTH;

    logic [i2cm_pkg::CFG_WIDTH-1:0] half_period_reg;

    logic       ivld_reg;
    logic [2:0] icmd_reg;
    logic [7:0] iwdata_reg;
    logic       inack_reg;
    logic       iscl_reg;
    logic       isda_reg;

    i2cm_pkg::phase_t phase_reg, phase_next;
    logic [3:0]    bit_count_reg, bit_count_next;
    logic [7:0]    shift_reg, shift_next;
    logic [CW-1:0] tick_reg, tick_next;
    logic          started_reg, started_next;
    logic          ack_reg, ack_next;
    logic          scl_drive_reg, scl_drive_next;
    logic          sda_drive_reg, sda_drive_next;
    logic          is_write_reg, is_write_next;
    logic          nack_send_reg, nack_send_next;
    logic [7:0]    rx_byte_reg, rx_byte_next;
    logic          done_next;

    logic       ovld_reg;
    logic       oscl_reg;
    logic       osda_reg;
    logic       obusy_reg;
    logic       odone_reg;
    logic [7:0] ordata_reg;
    logic       onack_reg;
    logic       ostarted_reg;

    logic          adv;
    logic [LW-1:0] hp_ext;
    logic [LW-1:0] mask_ext;
    logic [CW-1:0] delay_len;
    logic [CW-1:0] tick_inc;
    logic          delay_end;
    logic [CW-1:0] tick_after_delay;
    logic [7:0]    shift_hi;
    logic [3:0]    bit_inc;

    assign adv       = ivld_reg && (!ovld_reg || rsp.ready);
    assign req.ready = !ivld_reg || adv;

    always_comb
    begin
        hp_ext   = LW'(half_period_reg);
        mask_ext = LW'({CW{1'b1}});
        if (half_period_reg == '0)
        begin
            delay_len = CW'(1);
        end
        else if (hp_ext > mask_ext)
        begin
            delay_len = {CW{1'b1}};
        end
        else
        begin
            delay_len = hp_ext[CW-1:0];
        end
    end

    assign tick_inc         = tick_reg + CW'(1);
    assign delay_end        = (tick_inc >= delay_len) || (tick_inc == '0);
    assign tick_after_delay = delay_end ? '0 : tick_inc;
    assign bit_inc          = bit_count_reg + 4'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        started_next   = started_reg;
        ack_next       = ack_reg;
        scl_drive_next = scl_drive_reg;
        sda_drive_next = sda_drive_reg;
        is_write_next  = is_write_reg;
        nack_send_next = nack_send_reg;
        rx_byte_next   = rx_byte_reg;
        done_next      = 1'b0;
        shift_hi       = shift_reg;

        case (phase_reg)
            i2cm_pkg::PH_IDLE:
            begin
                tick_next = '0;
                if (icmd_reg == i2cm_pkg::CMD_START)
                begin
                    if (started_reg)
                    begin
                        sda_drive_next = 1'b0;
                        phase_next     = i2cm_pkg::PH_RS_SETUP;
                    end
                    else
                    begin
                        sda_drive_next = 1'b1;
                        phase_next     = i2cm_pkg::PH_ST_HOLD;
                    end
                end
                else if (icmd_reg == i2cm_pkg::CMD_STOP)
                begin
                    sda_drive_next = 1'b1;
                    phase_next     = i2cm_pkg::PH_SP_SETUP;
                end
                else if (icmd_reg == i2cm_pkg::CMD_WRITE || icmd_reg == i2cm_pkg::CMD_READ)
                begin
                    is_write_next  = (icmd_reg == i2cm_pkg::CMD_WRITE);
                    shift_next     = is_write_next ? iwdata_reg : 8'd0;
                    nack_send_next = inack_reg;
                    bit_count_next = 4'd0;
                    sda_drive_next = i2cm_pkg::bit_drive(is_write_next, 4'd0,
                                                         shift_next[7], inack_reg);
                    phase_next     = i2cm_pkg::PH_BIT_SETUP;
                end
            end
            i2cm_pkg::PH_RS_SETUP, i2cm_pkg::PH_SP_SETUP, i2cm_pkg::PH_BIT_SETUP:
            begin
                tick_next = tick_after_delay;
                if (delay_end)
                begin
                    scl_drive_next = 1'b0;
                    case (phase_reg)
                        i2cm_pkg::PH_RS_SETUP: phase_next = i2cm_pkg::PH_RS_WAIT;
                        i2cm_pkg::PH_SP_SETUP: phase_next = i2cm_pkg::PH_SP_WAIT;
                        default:               phase_next = i2cm_pkg::PH_BIT_WAIT;
                    endcase
                end
            end
            i2cm_pkg::PH_RS_WAIT, i2cm_pkg::PH_SP_WAIT, i2cm_pkg::PH_BIT_WAIT:
            begin
                if (iscl_reg)
                begin
                    tick_next = '0;
                    case (phase_reg)
                        i2cm_pkg::PH_RS_WAIT: phase_next = i2cm_pkg::PH_RS_HOLD;
                        i2cm_pkg::PH_SP_WAIT: phase_next = i2cm_pkg::PH_SP_HOLD;
                        default:              phase_next = i2cm_pkg::PH_BIT_HIGH;
                    endcase
                end
            end
            i2cm_pkg::PH_RS_HOLD:
            begin
                tick_next = tick_after_delay;
                if (delay_end)
                begin
                    sda_drive_next = 1'b1;
                    phase_next     = i2cm_pkg::PH_ST_HOLD;
                end
            end
            i2cm_pkg::PH_ST_HOLD:
            begin
                tick_next = tick_after_delay;
                if (delay_end)
                begin
                    scl_drive_next = 1'b1;
                    started_next   = 1'b1;
                    done_next      = 1'b1;
                    phase_next     = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_SP_HOLD:
            begin
                tick_next = tick_after_delay;
                if (delay_end)
                begin
                    sda_drive_next = 1'b0;
                    phase_next     = i2cm_pkg::PH_SP_TAIL;
                end
            end
            i2cm_pkg::PH_SP_TAIL:
            begin
                tick_next = tick_after_delay;
                if (delay_end)
                begin
                    started_next = 1'b0;
                    done_next    = 1'b1;
                    phase_next   = i2cm_pkg::PH_IDLE;
                end
            end
            i2cm_pkg::PH_BIT_HIGH:
            begin
                tick_next = tick_after_delay;
                if (delay_end)
                begin
                    if (is_write_reg)
                    begin
                        if (bit_count_reg < i2cm_pkg::BIT_ACK)
                        begin
                            shift_hi = {shift_reg[6:0], 1'b0};
                        end
                        else
                        begin
                            ack_next = isda_reg;
                        end
                    end
                    else if (bit_count_reg < i2cm_pkg::BIT_ACK)
                    begin
                        shift_hi = {shift_reg[6:0], isda_reg};
                        if (bit_count_reg == i2cm_pkg::BIT_LAST_DATA)
                        begin
                            rx_byte_next = shift_hi;
                        end
                    end
                    shift_next     = shift_hi;
                    scl_drive_next = 1'b1;
                    if (bit_inc > i2cm_pkg::BIT_ACK)
                    begin
                        bit_count_next = 4'd0;
                        done_next      = 1'b1;
                        phase_next     = i2cm_pkg::PH_IDLE;
                    end
                    else
                    begin
                        bit_count_next = bit_inc;
                        sda_drive_next = i2cm_pkg::bit_drive(is_write_reg, bit_inc,
                                                             shift_hi[7], nack_send_reg);
                        phase_next     = i2cm_pkg::PH_BIT_SETUP;
                    end
                end
            end
            default:
            begin
                phase_next = i2cm_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= i2cm_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            half_period_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivld_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                ivld_reg <= req.valid;
            end
            if (adv)
            begin
                ovld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            icmd_reg   <= req.cmd;
            iwdata_reg <= req.write_data;
            inack_reg  <= req.send_nack;
            iscl_reg   <= req.scl_in;
            isda_reg   <= req.sda_in;
        end
        if (adv)
        begin
            oscl_reg     <= scl_drive_next;
            osda_reg     <= sda_drive_next;
            obusy_reg    <= (phase_next != i2cm_pkg::PH_IDLE);
            odone_reg    <= done_next;
            ordata_reg   <= rx_byte_next;
            onack_reg    <= ack_next;
            ostarted_reg <= started_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            tick_reg      <= '0;
            started_reg   <= 1'b0;
            ack_reg       <= 1'b0;
            scl_drive_reg <= 1'b0;
            sda_drive_reg <= 1'b0;
            is_write_reg  <= 1'b0;
            nack_send_reg <= 1'b0;
            rx_byte_reg   <= 8'd0;
        end
        else if (adv)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            started_reg   <= started_next;
            ack_reg       <= ack_next;
            scl_drive_reg <= scl_drive_next;
            sda_drive_reg <= sda_drive_next;
            is_write_reg  <= is_write_next;
            nack_send_reg <= nack_send_next;
            rx_byte_reg   <= rx_byte_next;
        end
    end

    assign rsp.valid        = ovld_reg;
    assign rsp.scl_pull_low = oscl_reg;
    assign rsp.sda_pull_low = osda_reg;
    assign rsp.busy_res     = obusy_reg;
    assign rsp.done_res     = odone_reg;
    assign rsp.read_data    = ordata_reg;
    assign rsp.nack_seen    = onack_reg;
    assign rsp.bus_started  = ostarted_reg;

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.done_res) |-> !rsp.busy_res)
        else $error("completed command still reported busy");

    a_started_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && (started_next != started_reg)) |-> done_next)
        else $error("bus started flag changed without a completed command");

    a_idle_tick_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cm_pkg::PH_IDLE) |-> (tick_reg == '0))
        else $error("tick counter not cleared in idle");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= i2cm_pkg::BIT_ACK)
        else $error("bit counter beyond acknowledge bit");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(phase_reg) && $stable(tick_reg) && $stable(bit_count_reg)))
        else $error("sequencer state moved without a transaction");
`endif

endmodule

`default_nettype wire
